@@ hdl/sclru_pkg.sv @@
// shared types and constants of the split cache lookup block
package sclru_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 4;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 72;
  localparam int COUNT_W    = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ICACHE_INDEX_BITS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ICACHE_OFFSET_BITS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ICACHE_WAYS        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DCACHE_INDEX_BITS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DCACHE_OFFSET_BITS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DCACHE_WAYS        = 3'd5;

  // register values after reset
  localparam logic [CFG_DATA_W-1:0] RST_ICACHE_INDEX_BITS  = 4'd10;
  localparam logic [CFG_DATA_W-1:0] RST_ICACHE_OFFSET_BITS = 4'd3;
  localparam logic [CFG_DATA_W-1:0] RST_ICACHE_WAYS        = 4'd4;
  localparam logic [CFG_DATA_W-1:0] RST_DCACHE_INDEX_BITS  = 4'd10;
  localparam logic [CFG_DATA_W-1:0] RST_DCACHE_OFFSET_BITS = 4'd2;
  localparam logic [CFG_DATA_W-1:0] RST_DCACHE_WAYS        = 4'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PREP,
    ST_SCAN,
    ST_UPDATE
  } state_t;

endpackage

@@ hdl/split_cache_lru_lookup.sv @@
// split instruction/data set-associative cache lookup with true lru replacement
//
// one access per transfer on the s_ side: s_tuser selects the cache (1 instruction,
// 0 data), s_tdata carries the byte address. each access gives one result transfer
// on the m_ side with hit, way, fill flag and the running hit/miss counts of that
// cache; m_tuser repeats the cache select.
// both caches live in one row-wide memory, one row per set holding valid, rank and
// tag of every way. an access reads its row once, then a single tag/rank compare
// unit walks the n ways in use, one way a cycle, and the updated row is written back.
// m_tvalid rises once the access has passed the prep, scan and update states, the
// scan walking the n ways in use for that cache (1 to MAX_WAYS). s_tready is high only
// while idle, so a new access is taken only after the last one is written back.
// after reset a clearing pass writes every row of both caches, one row a cycle,
// 2 * 2^floor(log2(MAX_SETS)) rows (2048 with the defaults); s_tready stays low
// meanwhile, configuration writes are taken as ever. the result sits in an output
// register; if the receiver stalls, the next access is still taken and walked, then
// held before write-back until the register frees. the user writes configuration
// through cfg_we/cfg_index/cfg_data only while idle; the block does not enforce this.
module split_cache_lru_lookup
  import sclru_pkg::*;
#(
  parameter int MAX_SETS  = 1024,
  parameter int MAX_WAYS  = 8,
  parameter int ADDR_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // access stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // [31:0] address
  input  logic                  s_tuser,   // [0] action
  // result stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // [0] hit, [3:1] way, [4] filled_empty,
                                           // [36:5] hit_count, [68:37] miss_count
  output logic                  m_tuser    // [0] cache_used
);

  localparam int MAX_IB    = $clog2(MAX_SETS + 1) - 1;
  localparam int SETW      = (MAX_IB > 0) ? MAX_IB : 1;
  localparam int AW        = MAX_IB + 1;
  localparam int DEPTH     = 2 * (1 << MAX_IB);
  localparam int WW        = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int NW        = $clog2(MAX_WAYS + 1);
  localparam int RW        = WW;
  localparam int ENTRY_W   = ADDR_BITS + RW + 1;
  localparam int RANK_LSB  = ADDR_BITS;
  localparam int VALID_BIT = ADDR_BITS + RW;
  localparam logic [RW-1:0] RANK_MAX = RW'(MAX_WAYS - 1);

  state_t state, state_next;

  // configuration registers
  logic [CFG_DATA_W-1:0] icache_index_bits, icache_offset_bits, icache_ways;
  logic [CFG_DATA_W-1:0] dcache_index_bits, dcache_offset_bits, dcache_ways;

  // row memory, both caches
  logic [MAX_WAYS-1:0][ENTRY_W-1:0] mem [DEPTH];
  logic [MAX_WAYS-1:0][ENTRY_W-1:0] row_r;
  logic [MAX_WAYS-1:0][ENTRY_W-1:0] new_row;
  logic [MAX_WAYS-1:0][ENTRY_W-1:0] wdata;
  logic [AW-1:0]                    raddr, waddr, clr_addr;
  logic                             mem_we, clr_last;

  // access being worked on
  logic                 act_r;
  logic [ADDR_BITS-1:0] addr_r;
  logic [SETW-1:0]      set_r;
  logic [ADDR_BITS-1:0] tag_r;
  logic [NW-1:0]        n_r;

  // address split
  logic [CFG_DATA_W-1:0] ib_cfg, ob_cfg, ways_cfg;
  logic [4:0]            ib_eff;
  logic [5:0]            tag_shift;
  logic [NW-1:0]         n_eff;
  logic [ADDR_BITS-1:0]  set_full, tag_full;
  logic [SETW-1:0]       set_c;

  // way walk
  logic [WW-1:0]        way_idx;
  logic [ENTRY_W-1:0]   cur;
  logic [RW-1:0]        cur_rank;
  logic                 scan_last;
  logic                 hit_f, inv_f;
  logic [WW-1:0]        hit_w, inv_w, best_w;
  logic [RW-1:0]        best_rank;

  // update
  logic [WW-1:0]        sel_w;
  logic                 was_valid, filled;
  logic [RW-1:0]        old_rank;
  logic                 update_go;

  // counters
  logic [COUNT_W-1:0] icache_hits, icache_misses, dcache_hits, dcache_misses;
  logic [COUNT_W-1:0] hits_sel, misses_sel, hits_new, misses_new;

  // output register
  logic                 out_valid;
  logic                 out_hit, out_cache, out_filled;
  logic [2:0]           out_way;
  logic [COUNT_W-1:0]   out_hits, out_misses;

  // ---------------------------------------------------------------- configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      icache_index_bits  <= RST_ICACHE_INDEX_BITS;
      icache_offset_bits <= RST_ICACHE_OFFSET_BITS;
      icache_ways        <= RST_ICACHE_WAYS;
      dcache_index_bits  <= RST_DCACHE_INDEX_BITS;
      dcache_offset_bits <= RST_DCACHE_OFFSET_BITS;
      dcache_ways        <= RST_DCACHE_WAYS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ICACHE_INDEX_BITS:  icache_index_bits  <= cfg_data;
        REG_ICACHE_OFFSET_BITS: icache_offset_bits <= cfg_data;
        REG_ICACHE_WAYS:        icache_ways        <= cfg_data;
        REG_DCACHE_INDEX_BITS:  dcache_index_bits  <= cfg_data;
        REG_DCACHE_OFFSET_BITS: dcache_offset_bits <= cfg_data;
        REG_DCACHE_WAYS:        dcache_ways        <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- address split
  always_comb begin
    ib_cfg   = act_r ? icache_index_bits  : dcache_index_bits;
    ob_cfg   = act_r ? icache_offset_bits : dcache_offset_bits;
    ways_cfg = act_r ? icache_ways        : dcache_ways;

    ib_eff = ({1'b0, ib_cfg} > 5'(MAX_IB)) ? 5'(MAX_IB) : {1'b0, ib_cfg};

    if (ways_cfg == '0) begin
      n_eff = NW'(1);
    end else if (32'(ways_cfg) > 32'(MAX_WAYS)) begin
      n_eff = NW'(MAX_WAYS);
    end else begin
      n_eff = NW'(ways_cfg);
    end

    set_full  = (addr_r >> ob_cfg) & ~({ADDR_BITS{1'b1}} << ib_eff);
    set_c     = set_full[SETW-1:0];
    tag_shift = 6'(ob_cfg) + 6'(ib_eff);
    tag_full  = addr_r >> tag_shift;
    raddr     = (AW'(act_r) << MAX_IB) | AW'(set_c);
  end

  // ---------------------------------------------------------------- row memory
  assign waddr    = (state == ST_CLEAR) ? clr_addr : ((AW'(act_r) << MAX_IB) | AW'(set_r));
  assign wdata    = (state == ST_CLEAR) ? '0 : new_row;
  assign clr_last = (clr_addr == AW'(DEPTH - 1));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (state == ST_PREP) begin
      row_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == ST_CLEAR) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  // ---------------------------------------------------------------- access registers
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      act_r  <= s_tuser;
      addr_r <= s_tdata[ADDR_BITS-1:0];
    end
    if (state == ST_PREP) begin
      set_r <= set_c;
      tag_r <= tag_full;
      n_r   <= n_eff;
    end
  end

  // ---------------------------------------------------------------- shared compare unit
  assign cur       = row_r[way_idx];
  assign cur_rank  = cur[RANK_LSB +: RW];
  assign scan_last = (NW'(way_idx) + NW'(1) == n_r);

  always_ff @(posedge clk) begin
    if (state == ST_PREP) begin
      way_idx   <= '0;
      hit_f     <= 1'b0;
      inv_f     <= 1'b0;
      hit_w     <= '0;
      inv_w     <= '0;
      best_w    <= '0;
      best_rank <= '0;
    end else if (state == ST_SCAN) begin
      way_idx <= way_idx + WW'(1);
      // lowest matching way wins
      if (!hit_f && cur[VALID_BIT] && cur[ADDR_BITS-1:0] == tag_r) begin
        hit_f <= 1'b1;
        hit_w <= way_idx;
      end
      if (!inv_f && !cur[VALID_BIT]) begin
        inv_f <= 1'b1;
        inv_w <= way_idx;
      end
      // strict compare keeps the lowest way on equal ranks
      if (way_idx == '0 || cur_rank > best_rank) begin
        best_w    <= way_idx;
        best_rank <= cur_rank;
      end
    end
  end

  // ---------------------------------------------------------------- row update
  always_comb begin
    sel_w     = hit_f ? hit_w : (inv_f ? inv_w : best_w);
    filled    = !hit_f && inv_f;
    was_valid = !filled;
    old_rank  = row_r[sel_w][RANK_LSB +: RW];
    new_row   = row_r;
    for (int k = 0; k < MAX_WAYS; k++) begin
      if (WW'(k) == sel_w) begin
        new_row[k][VALID_BIT]         = 1'b1;
        new_row[k][RANK_LSB +: RW]    = '0;
        new_row[k][ADDR_BITS-1:0]     = hit_f ? row_r[k][ADDR_BITS-1:0] : tag_r;
      end else if (row_r[k][VALID_BIT] &&
                   (!was_valid || row_r[k][RANK_LSB +: RW] < old_rank) &&
                   row_r[k][RANK_LSB +: RW] < RANK_MAX) begin
        // ageing, saturating at the oldest rank
        new_row[k][RANK_LSB +: RW] = row_r[k][RANK_LSB +: RW] + RW'(1);
      end
    end
  end

  // ---------------------------------------------------------------- counters
  always_comb begin
    hits_sel   = act_r ? icache_hits   : dcache_hits;
    misses_sel = act_r ? icache_misses : dcache_misses;
    hits_new   = hits_sel;
    misses_new = misses_sel;
    if (hit_f) begin
      if (hits_sel != '1) begin
        hits_new = hits_sel + COUNT_W'(1);
      end
    end else begin
      if (misses_sel != '1) begin
        misses_new = misses_sel + COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      icache_hits   <= '0;
      icache_misses <= '0;
      dcache_hits   <= '0;
      dcache_misses <= '0;
    end else if (update_go) begin
      if (act_r) begin
        icache_hits   <= hits_new;
        icache_misses <= misses_new;
      end else begin
        dcache_hits   <= hits_new;
        dcache_misses <= misses_new;
      end
    end
  end

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    mem_we     = 1'b0;
    update_go  = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
        if (clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        // hold the write-back until the result register can take the result
        if (!out_valid || m_tready) begin
          mem_we     = 1'b1;
          update_go  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (update_go) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (update_go) begin
      out_hit    <= hit_f;
      out_cache  <= act_r;
      out_way    <= 3'(sel_w);
      out_filled <= filled;
      out_hits   <= hits_new;
      out_misses <= misses_new;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_cache;
  assign m_tdata  = {3'b000, out_misses, out_hits, out_filled, out_way, out_hit};

endmodule
